@@ hw/rtl/scpc_pkg.sv @@
// Package for the servo channel position control core.
// Holds field widths, request and register codes, stack control structs
// and the position clamp. No dependencies.
package scpc_pkg;

  localparam int unsigned SAVE_DEPTH_DEF = 8;

  localparam int unsigned REQ_W    = 3;
  localparam int unsigned ANGLE_W  = 12;
  localparam int unsigned POFF_W   = 12;
  localparam int unsigned CHAN_W   = 5;
  localparam int unsigned PULSE_W  = 12;
  localparam int unsigned POS_W    = 11;
  localparam int unsigned TRIM_W   = 10;
  localparam int unsigned LIMIT_W  = 9;
  localparam int unsigned WIDE_W   = 14;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic signed [WIDE_W-1:0] POS_MIN    = -14'sd1000;
  localparam logic signed [WIDE_W-1:0] POS_MAX    = 14'sd1000;
  localparam logic signed [WIDE_W-1:0] ANGLE_LO   = -14'sd2048;
  localparam logic signed [WIDE_W-1:0] ANGLE_HI   = 14'sd2047;
  localparam logic signed [WIDE_W-1:0] TENTHS     = 14'sd10;
  localparam logic [PULSE_W-1:0]       PULSE_MID  = 12'd1500;

  typedef enum logic [REQ_W-1:0] {
    REQ_SET_ANGLE = 3'd0,
    REQ_ADD_ANGLE = 3'd1,
    REQ_ADD_PULSE = 3'd2,
    REQ_CENTER    = 3'd3,
    REQ_SAVE      = 3'd4,
    REQ_RESTORE   = 3'd5,
    REQ_CLEAR     = 3'd6
  } req_type_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNEL_ID = 3'd0,
    CFG_TRIM       = 3'd1,
    CFG_INVERT_DIR = 3'd2,
    CFG_MIN_ANGLE  = 3'd3,
    CFG_MAX_ANGLE  = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic                    push;
    logic                    pop;
    logic signed [POS_W-1:0] wdata;
  } stack_ctl_t;

  typedef struct packed {
    logic                    empty;
    logic                    full;
    logic signed [POS_W-1:0] top;
  } stack_sts_t;

  function automatic logic signed [POS_W-1:0] clamp_pos(input logic signed [WIDE_W-1:0] p);
    logic signed [WIDE_W-1:0] c;
    c = p;
    if (p < POS_MIN) begin
      c = POS_MIN;
    end else if (p > POS_MAX) begin
      c = POS_MAX;
    end
    return c[POS_W-1:0];
  endfunction

endpackage

@@ hw/rtl/scpc_in_if.sv @@
// Request channel interface for the servo channel core.
// Depends on scpc_pkg for field widths.
interface scpc_in_if import scpc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic signed [ANGLE_W-1:0] angle_value;
  logic signed [POFF_W-1:0]  pulse_offset;

  modport source (output valid, req_type, angle_value, pulse_offset, input ready);
  modport sink   (input valid, req_type, angle_value, pulse_offset, output ready);
endinterface

@@ hw/rtl/scpc_out_if.sv @@
// Result channel interface for the servo channel core.
// Depends on scpc_pkg for field widths.
interface scpc_out_if import scpc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CHAN_W-1:0]  out_channel;
  logic [PULSE_W-1:0] pulse_us;
  logic               changed_flag;
  logic               angle_rejected;
  logic               save_full;

  modport source (output valid, out_channel, pulse_us, changed_flag, angle_rejected,
                  save_full, input ready);
  modport sink   (input valid, out_channel, pulse_us, changed_flag, angle_rejected,
                  save_full, output ready);
endinterface

@@ hw/rtl/scpc_cfg_if.sv @@
// Configuration write channel interface for the servo channel core.
// Depends on scpc_pkg for index and data widths.
interface scpc_cfg_if import scpc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/servo_channel_position_control_core.sv @@
// Servo channel position control core: top level.
// Requests pass the input register and then the result register; one request per
// cycle unless out_if stalls; the state update is one compare/add/clamp pass.
// Reset: synchronous active-low rst_n clears position, angle, flags, stack count and
// restores the default register values; the save store needs no clearing pass.
module servo_channel_position_control_core import scpc_pkg::*; #(
  parameter int unsigned SAVE_DEPTH = SAVE_DEPTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  scpc_in_if.sink    in_if,
  scpc_out_if.source out_if,
  scpc_cfg_if.sink   cfg_if
);

  // configuration registers
  logic [CHAN_W-1:0]          cfg_chan_r;
  logic signed [TRIM_W-1:0]   cfg_trim_r;
  logic                       cfg_inv_r;
  logic signed [LIMIT_W-1:0]  cfg_min_r;
  logic signed [LIMIT_W-1:0]  cfg_max_r;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_chan_r <= '0;
      cfg_trim_r <= '0;
      cfg_inv_r  <= 1'b0;
      cfg_min_r  <= -9'sd90;
      cfg_max_r  <= 9'sd90;
    end else if (cfg_if.valid) begin
      case (cfg_index_t'(cfg_if.index))
        CFG_CHANNEL_ID: cfg_chan_r <= cfg_if.data[CHAN_W-1:0];
        CFG_TRIM:       cfg_trim_r <= cfg_if.data[TRIM_W-1:0];
        CFG_INVERT_DIR: cfg_inv_r  <= cfg_if.data[0];
        CFG_MIN_ANGLE:  cfg_min_r  <= cfg_if.data[LIMIT_W-1:0];
        CFG_MAX_ANGLE:  cfg_max_r  <= cfg_if.data[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register stage
  logic                      s1_valid_r;
  logic [REQ_W-1:0]          s1_req_r;
  logic signed [ANGLE_W-1:0] s1_angle_r;
  logic signed [POFF_W-1:0]  s1_poff_r;
  logic                      out_valid_r;
  logic                      out_free;
  logic                      fire;

  assign out_free    = !out_valid_r || out_if.ready;
  assign fire        = s1_valid_r && out_free;
  assign in_if.ready = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      s1_req_r   <= in_if.req_type;
      s1_angle_r <= in_if.angle_value;
      s1_poff_r  <= in_if.pulse_offset;
    end
  end

  // channel state
  logic signed [ANGLE_W-1:0] angle_r, angle_nxt;
  logic signed [POS_W-1:0]   pos_r, pos_nxt;
  logic                      changed_r, changed_nxt;
  logic                      rejected;
  logic                      full_flag;
  stack_ctl_t                stk_ctl;
  stack_sts_t                stk_sts;

  logic signed [WIDE_W-1:0]  cand;
  logic signed [WIDE_W-1:0]  lo_lim, hi_lim;
  logic signed [WIDE_W-1:0]  trim_w;
  logic signed [WIDE_W-1:0]  ang_pos;
  logic signed [WIDE_W-1:0]  off_pos;
  logic                      ang_ok;

  always_comb begin
    trim_w  = WIDE_W'(cfg_trim_r);
    lo_lim  = WIDE_W'(cfg_min_r) * TENTHS;
    hi_lim  = WIDE_W'(cfg_max_r) * TENTHS;
    if (req_type_t'(s1_req_r) == REQ_ADD_ANGLE) begin
      cand = WIDE_W'(angle_r) + WIDE_W'(s1_angle_r);
    end else begin
      cand = WIDE_W'(s1_angle_r);
    end
    ang_ok = (cand >= ANGLE_LO) && (cand <= ANGLE_HI) && (cand >= lo_lim) && (cand <= hi_lim);
    ang_pos = cfg_inv_r ? (-cand - trim_w) : (cand + trim_w);
    off_pos = cfg_inv_r ? (WIDE_W'(pos_r) - WIDE_W'(s1_poff_r))
                        : (WIDE_W'(pos_r) + WIDE_W'(s1_poff_r));

    angle_nxt     = angle_r;
    pos_nxt       = pos_r;
    changed_nxt   = changed_r;
    rejected      = 1'b0;
    full_flag     = 1'b0;
    stk_ctl.push  = 1'b0;
    stk_ctl.pop   = 1'b0;
    stk_ctl.wdata = pos_r;

    case (req_type_t'(s1_req_r))
      REQ_SET_ANGLE, REQ_ADD_ANGLE: begin
        if (ang_ok) begin
          angle_nxt   = cand[ANGLE_W-1:0];
          pos_nxt     = clamp_pos(ang_pos);
          changed_nxt = 1'b1;
        end else begin
          rejected = 1'b1;
        end
      end
      REQ_ADD_PULSE: begin
        pos_nxt = clamp_pos(off_pos);
        if (s1_poff_r != '0) begin
          changed_nxt = 1'b1;
        end
      end
      REQ_CENTER: begin
        pos_nxt     = clamp_pos(cfg_inv_r ? -trim_w : trim_w);
        changed_nxt = 1'b1;
      end
      REQ_SAVE: begin
        if (stk_sts.full) begin
          full_flag = 1'b1;
        end else begin
          stk_ctl.push = fire;
        end
      end
      REQ_RESTORE: begin
        if (!stk_sts.empty) begin
          stk_ctl.pop = fire;
          pos_nxt     = stk_sts.top;
          if (stk_sts.top != pos_r) begin
            changed_nxt = 1'b1;
          end
        end
      end
      REQ_CLEAR: begin
        changed_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r   <= '0;
      pos_r     <= '0;
      changed_r <= 1'b0;
    end else if (fire) begin
      angle_r   <= angle_nxt;
      pos_r     <= pos_nxt;
      changed_r <= changed_nxt;
    end
  end

  scpc_stack #(
    .DEPTH (SAVE_DEPTH)
  ) u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (stk_ctl),
    .sts   (stk_sts)
  );

  // result register
  logic [CHAN_W-1:0]  res_chan_r;
  logic [PULSE_W-1:0] res_pulse_r;
  logic               res_changed_r;
  logic               res_rej_r;
  logic               res_full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_chan_r    <= cfg_chan_r;
      res_pulse_r   <= PULSE_W'(pos_nxt) + PULSE_MID;
      res_changed_r <= changed_nxt;
      res_rej_r     <= rejected;
      res_full_r    <= full_flag;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.out_channel    = res_chan_r;
  assign out_if.pulse_us       = res_pulse_r;
  assign out_if.changed_flag   = res_changed_r;
  assign out_if.angle_rejected = res_rej_r;
  assign out_if.save_full      = res_full_r;

endmodule

@@ hw/rtl/scpc_stack.sv @@
// Bounded LIFO of saved positions: memory plus top and second-entry registers.
// Depends on scpc_pkg for the control and status structs.
module scpc_stack import scpc_pkg::*; #(
  parameter int unsigned DEPTH = SAVE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  stack_ctl_t ctl,
  output stack_sts_t sts
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] TWO_C   = CW'(2);

  logic signed [POS_W-1:0] mem [DEPTH];
  logic [CW-1:0]           count_r, count_nxt;
  logic signed [POS_W-1:0] top_r;
  logic signed [POS_W-1:0] second_r;
  logic [CW-1:0]           rd_idx;

  always_comb begin
    count_nxt = count_r;
    if (ctl.push) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.pop) begin
      count_nxt = count_r - CW'(1);
    end
    rd_idx = count_nxt - TWO_C;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // second_r tracks the entry just below the top
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[count_r[AW-1:0]] <= ctl.wdata;
      top_r <= ctl.wdata;
    end else if (ctl.pop) begin
      top_r <= second_r;
    end
    second_r <= mem[rd_idx[AW-1:0]];
  end

  assign sts.empty = (count_r == '0);
  assign sts.full  = (count_r == DEPTH_C);
  assign sts.top   = top_r;

endmodule
